// ===== hw/rtl/fbik_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbik_pkg
// Widths, constants and helpers shared by the five-bar inverse kinematics
// pipeline and its cells.
// ----------------------------------------------------------------------------
package fbik_pkg;

    // Field widths
    localparam int COORD_W   = 24;
    localparam int LEN_W     = 23;
    localparam int LIM_W     = 20;
    localparam int ANGLE_W   = 20;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 23;

    // Internal widths
    localparam int XD_W   = COORD_W + 1;
    localparam int R_W    = 25;
    localparam int NUM_W  = 52;
    localparam int DEN_W  = 50;
    localparam int REM_W  = 51;
    localparam int QUO_W  = 31;
    localparam int ANG_W  = 35;
    localparam int Q16_W  = 21;
    localparam int Q16_SHIFT = 14;

    // Square root cells
    localparam int SQ_RAD_W  = 62;
    localparam int SQ_REM_W  = 35;
    localparam int SQ_ROOT_W = 31;
    localparam int SQ_STEPS  = 31;

    // Divider cells
    localparam int DIV_STEPS = 31;

    // CORDIC cells
    localparam int CD_W         = 48;
    localparam int CZ_W         = 33;
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_W       = 5;
    localparam int ATAN_TAB_N   = 11;
    localparam int ATAN_W       = 31;

    // Fixed origin, Q3.20
    localparam logic signed [COORD_W-1:0] ORIGIN_X = '0;
    localparam logic signed [COORD_W-1:0] ORIGIN_Z = '0;

    // Angles in Q.30
    localparam logic signed [ANG_W-1:0] PI_Q30  = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0] PIH_Q30 = 35'sd1686629713;
    localparam logic signed [ANG_W-1:0] ROUND_HALF = 35'sd8192;
    localparam logic [SQ_RAD_W-1:0] ONE_SQ_Q60 = 62'h1000_0000_0000_0000;

    localparam logic [ATAN_W-1:0] ATAN_TAB [0:ATAN_TAB_N-1] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159,
        31'd67021687,  31'd33543516,  31'd16775851,  31'd8388437,
        31'd4194283,   31'd2097149,   31'd1048576
    };

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REACH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_LEN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIP_LEN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT1_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT1_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT2_MAX    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT2_MIN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PASSIVE_MAX = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PASSIVE_MIN = 3'd7;

    // Reset values
    localparam logic [LEN_W-1:0] RST_LINK_LEN = 23'd209715;
    localparam logic [LEN_W-1:0] RST_TIP_LEN  = 23'd26214;
    localparam logic signed [LIM_W-1:0] RST_LIM_MAX = 20'sd205887;
    localparam logic signed [LIM_W-1:0] RST_LIM_MIN = -20'sd205887;

    // Rotation angle of one CORDIC step, Q.30
    function automatic logic [ATAN_W-1:0] fbik_atan(input logic [STEP_W-1:0] step);
        logic [ATAN_W-1:0] one;
        one = {{(ATAN_W-1){1'b0}}, 1'b1};
        if (step < STEP_W'(ATAN_TAB_N)) begin
            return ATAN_TAB[step[3:0]];
        end
        return one << (STEP_W'(30) - step);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fbik_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbik_sqrt_cell
// One digit step of a restoring integer square root: brings down two
// radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
module fbik_sqrt_cell (
    input  logic                             i_clk,
    input  logic [fbik_pkg::SQ_RAD_W-1:0]    i_rad,
    input  logic [fbik_pkg::SQ_REM_W-1:0]    i_rem,
    input  logic [fbik_pkg::SQ_ROOT_W-1:0]   i_root,
    output logic [fbik_pkg::SQ_RAD_W-1:0]    o_rad,
    output logic [fbik_pkg::SQ_REM_W-1:0]    o_rem,
    output logic [fbik_pkg::SQ_ROOT_W-1:0]   o_root
);
    import fbik_pkg::*;

    logic [SQ_REM_W-1:0]  rem_sh;
    logic [SQ_REM_W-1:0]  trial;
    logic                 ge;
    logic [SQ_REM_W-1:0]  n_rem;
    logic [SQ_RAD_W-1:0]  r_rad;
    logic [SQ_REM_W-1:0]  r_rem;
    logic [SQ_ROOT_W-1:0] r_root;

    always_comb begin
        rem_sh = {i_rem[SQ_REM_W-3:0], i_rad[SQ_RAD_W-1 -: 2]};
        trial  = SQ_REM_W'({i_root, 2'b01});
        ge     = (rem_sh >= trial);
        n_rem  = ge ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= {i_rad[SQ_RAD_W-3:0], 2'b00};
        r_rem  <= n_rem;
        r_root <= {i_root[SQ_ROOT_W-2:0], ge};
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule
`default_nettype wire

// ===== hw/rtl/fbik_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbik_div_cell
// One step of a restoring divider: compare, subtract, shift, one quotient
// bit.
// ----------------------------------------------------------------------------
module fbik_div_cell (
    input  logic                          i_clk,
    input  logic [fbik_pkg::REM_W-1:0]    i_rem,
    input  logic [fbik_pkg::DEN_W-1:0]    i_den,
    input  logic [fbik_pkg::QUO_W-1:0]    i_quo,
    output logic [fbik_pkg::REM_W-1:0]    o_rem,
    output logic [fbik_pkg::DEN_W-1:0]    o_den,
    output logic [fbik_pkg::QUO_W-1:0]    o_quo
);
    import fbik_pkg::*;

    logic             ge;
    logic [REM_W-1:0] n_rem;
    logic [REM_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QUO_W-1:0] r_quo;

    always_comb begin
        ge    = (i_rem >= REM_W'(i_den));
        n_rem = ge ? (i_rem - REM_W'(i_den)) : i_rem;
    end

    always_ff @(posedge i_clk) begin
        r_rem <= {n_rem[REM_W-2:0], 1'b0};
        r_den <= i_den;
        r_quo <= {i_quo[QUO_W-2:0], ge};
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;

endmodule
`default_nettype wire

// ===== hw/rtl/fbik_cordic_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbik_cordic_cell
// One vectoring-mode CORDIC rotation; the step number is tied off at the
// instance, so the shifts collapse to wiring.
// ----------------------------------------------------------------------------
module fbik_cordic_cell (
    input  logic                                 i_clk,
    input  logic [fbik_pkg::STEP_W-1:0]          i_step,
    input  logic signed [fbik_pkg::CD_W-1:0]     i_x,
    input  logic signed [fbik_pkg::CD_W-1:0]     i_y,
    input  logic signed [fbik_pkg::CZ_W-1:0]     i_z,
    output logic signed [fbik_pkg::CD_W-1:0]     o_x,
    output logic signed [fbik_pkg::CD_W-1:0]     o_y,
    output logic signed [fbik_pkg::CZ_W-1:0]     o_z
);
    import fbik_pkg::*;

    logic signed [CD_W-1:0] dx;
    logic signed [CD_W-1:0] dy;
    logic signed [CZ_W-1:0] ang;
    logic signed [CD_W-1:0] n_x;
    logic signed [CD_W-1:0] n_y;
    logic signed [CZ_W-1:0] n_z;
    logic signed [CD_W-1:0] r_x;
    logic signed [CD_W-1:0] r_y;
    logic signed [CZ_W-1:0] r_z;

    always_comb begin
        dx  = i_y >>> i_step;
        dy  = i_x >>> i_step;
        ang = $signed(CZ_W'(fbik_atan(i_step)));
        if (!i_y[CD_W-1]) begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ang;
        end else begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ang;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule
`default_nettype wire

// ===== hw/rtl/five_bar_inverse_kinematics.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one transaction per cycle; o_busy is low except just out of reset.
// The pipeline depth is set by the cell chains: reach root (31), divider (31),
// acos root (31) and CORDIC (30), plus fifteen arithmetic stages.
// Reset (synchronous) clears the pipeline and loads the default registers.
// Results cannot be stalled; each shows for one cycle on o_valid.
// ----------------------------------------------------------------------------
// five_bar_inverse_kinematics
// Law-of-cosines inverse kinematics for a five-bar linkage as a fully
// pipelined chain of root, divider and CORDIC cells.
// ----------------------------------------------------------------------------
module five_bar_inverse_kinematics (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    output logic                                   o_busy,
    input  logic signed [fbik_pkg::COORD_W-1:0]    i_target_x,
    input  logic signed [fbik_pkg::COORD_W-1:0]    i_target_z,
    input  logic                                   i_cfg_we,
    input  logic [fbik_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [fbik_pkg::CFG_DAT_W-1:0]         i_cfg_data,
    output logic                                   o_valid,
    output logic signed [fbik_pkg::ANGLE_W-1:0]    o_angle_act1,
    output logic signed [fbik_pkg::ANGLE_W-1:0]    o_angle_act2,
    output logic signed [fbik_pkg::ANGLE_W-1:0]    o_angle_passive,
    output logic [fbik_pkg::STATUS_W-1:0]          o_status
);
    import fbik_pkg::*;

    typedef struct packed {
        logic                    vld;
        logic signed [XD_W-1:0]  xd;
        logic signed [XD_W-1:0]  zd;
        logic                    ok;
        logic                    sg_b;
        logic                    sg_g;
        logic                    neg_b;
        logic                    neg_g;
        logic [QUO_W-1:0]        qb;
        logic [QUO_W-1:0]        qg;
    } t_side;

    function automatic logic signed [Q16_W-1:0] to_q16(input logic signed [ANG_W-1:0] v);
        logic signed [ANG_W-1:0] s;
        s = (v + ROUND_HALF) >>> Q16_SHIFT;
        return s[Q16_W-1:0];
    endfunction

    function automatic logic outside(input logic signed [Q16_W-1:0] v,
                                     input logic signed [LIM_W-1:0] lo,
                                     input logic signed [LIM_W-1:0] hi);
        return (v > Q16_W'(hi)) || (v < Q16_W'(lo));
    endfunction

    // ---------------- configuration ----------------
    logic                    r_busy;
    logic [LEN_W-1:0]        r_link_len;
    logic [LEN_W-1:0]        r_tip_len;
    logic signed [LIM_W-1:0] r_act1_max;
    logic signed [LIM_W-1:0] r_act1_min;
    logic signed [LIM_W-1:0] r_act2_max;
    logic signed [LIM_W-1:0] r_act2_min;
    logic signed [LIM_W-1:0] r_passive_max;
    logic signed [LIM_W-1:0] r_passive_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b1;
            r_link_len    <= RST_LINK_LEN;
            r_tip_len     <= RST_TIP_LEN;
            r_act1_max    <= RST_LIM_MAX;
            r_act1_min    <= RST_LIM_MIN;
            r_act2_max    <= RST_LIM_MAX;
            r_act2_min    <= RST_LIM_MIN;
            r_passive_max <= RST_LIM_MAX;
            r_passive_min <= RST_LIM_MIN;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LINK_LEN:    r_link_len    <= i_cfg_data;
                    CFG_TIP_LEN:     r_tip_len     <= i_cfg_data;
                    CFG_ACT1_MAX:    r_act1_max    <= i_cfg_data[LIM_W-1:0];
                    CFG_ACT1_MIN:    r_act1_min    <= i_cfg_data[LIM_W-1:0];
                    CFG_ACT2_MAX:    r_act2_max    <= i_cfg_data[LIM_W-1:0];
                    CFG_ACT2_MIN:    r_act2_min    <= i_cfg_data[LIM_W-1:0];
                    CFG_PASSIVE_MAX: r_passive_max <= i_cfg_data[LIM_W-1:0];
                    CFG_PASSIVE_MIN: r_passive_min <= i_cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_busy = r_busy;

    // ---------------- stages A..C: offset, squares, sum ----------------
    t_side                  n_a_sd;
    t_side                  r_a_sd, r_b_sd, r_c_sd;
    logic [2*XD_W-2:0]      r_b_sqx, r_b_sqz;
    logic [2*XD_W-1:0]      r_c_sum;
    logic signed [2*XD_W-1:0] p_sqx, p_sqz;

    assign p_sqx = r_a_sd.xd * r_a_sd.xd;
    assign p_sqz = r_a_sd.zd * r_a_sd.zd;

    always_comb begin
        n_a_sd     = '0;
        n_a_sd.vld = i_start && !r_busy;
        n_a_sd.xd  = XD_W'(i_target_x) - XD_W'(ORIGIN_X);
        n_a_sd.zd  = XD_W'(i_target_z) - XD_W'(ORIGIN_Z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_sd <= '0;
            r_b_sd <= '0;
            r_c_sd <= '0;
        end else begin
            r_a_sd <= n_a_sd;
            r_b_sd <= r_a_sd;
            r_c_sd <= r_b_sd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_sqx <= p_sqx[2*XD_W-2:0];
        r_b_sqz <= p_sqz[2*XD_W-2:0];
        r_c_sum <= (2*XD_W)'(r_b_sqx) + (2*XD_W)'(r_b_sqz);
    end

    // ---------------- reach square root ----------------
    logic [SQ_RAD_W-1:0]  w_rs_rad  [0:SQ_STEPS];
    logic [SQ_REM_W-1:0]  w_rs_rem  [0:SQ_STEPS];
    logic [SQ_ROOT_W-1:0] w_rs_root [0:SQ_STEPS];
    t_side                r_sd1     [0:SQ_STEPS-1];

    assign w_rs_rad[0]  = SQ_RAD_W'(r_c_sum);
    assign w_rs_rem[0]  = '0;
    assign w_rs_root[0] = '0;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_rs
        fbik_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rad  (w_rs_rad[k]),
            .i_rem  (w_rs_rem[k]),
            .i_root (w_rs_root[k]),
            .o_rad  (w_rs_rad[k+1]),
            .o_rem  (w_rs_rem[k+1]),
            .o_root (w_rs_root[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQ_STEPS; k++) r_sd1[k] <= '0;
        end else begin
            r_sd1[0] <= r_c_sd;
            for (int k = 1; k < SQ_STEPS; k++) r_sd1[k] <= r_sd1[k-1];
        end
    end

    // ---------------- stages D..G: cosine numerators and denominators ----------------
    logic [R_W-1:0]   reach;
    logic [LEN_W:0]   m_len;
    logic [R_W-1:0]   reach_lim;
    logic [2*R_W-1:0] p_rr;
    logic [2*LEN_W-1:0] p_ll;
    logic [2*LEN_W+1:0] p_mm;
    logic [2*LEN_W:0]   p_lm;
    logic [LEN_W+R_W-1:0] p_lr;

    t_side r_d_sd, r_e_sd, r_f_sd, r_g_sd;
    t_side n_d_sd, n_f_sd, n_g_sd;
    logic [2*R_W-1:0]       r_d_rr;
    logic [2*LEN_W-1:0]     r_d_ll;
    logic [2*LEN_W+1:0]     r_d_mm;
    logic [2*LEN_W:0]       r_d_lm;
    logic [LEN_W+R_W-1:0]   r_d_lr;
    logic signed [NUM_W-1:0] r_e_nb, r_e_ng;
    logic [DEN_W-1:0]       r_e_db, r_e_dg, r_f_db, r_f_dg, r_g_db, r_g_dg;
    logic [REM_W-1:0]       r_f_anb, r_f_ang, r_g_anb, r_g_ang;

    always_comb begin
        reach     = w_rs_root[SQ_STEPS][R_W-1:0];
        m_len     = (LEN_W+1)'(r_link_len) + (LEN_W+1)'(r_tip_len);
        reach_lim = R_W'({r_link_len, 1'b0}) + R_W'(r_tip_len);
        p_rr      = reach * reach;
        p_ll      = r_link_len * r_link_len;
        p_mm      = m_len * m_len;
        p_lm      = r_link_len * m_len;
        p_lr      = r_link_len * reach;
    end

    always_comb begin
        n_d_sd      = r_sd1[SQ_STEPS-1];
        n_d_sd.ok   = (reach != '0) && (reach <= reach_lim) && (r_link_len != '0);
        n_f_sd      = r_e_sd;
        n_f_sd.sg_b = r_e_nb[NUM_W-1];
        n_f_sd.sg_g = r_e_ng[NUM_W-1];
        n_g_sd      = r_f_sd;
        n_g_sd.ok   = r_f_sd.ok && (r_f_anb <= REM_W'(r_f_db))
                      && (r_f_ang <= REM_W'(r_f_dg));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_sd <= '0;
            r_e_sd <= '0;
            r_f_sd <= '0;
            r_g_sd <= '0;
        end else begin
            r_d_sd <= n_d_sd;
            r_e_sd <= r_d_sd;
            r_f_sd <= n_f_sd;
            r_g_sd <= n_g_sd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_rr  <= p_rr;
        r_d_ll  <= p_ll;
        r_d_mm  <= p_mm;
        r_d_lm  <= p_lm;
        r_d_lr  <= p_lr;
        r_e_nb  <= $signed(NUM_W'(r_d_ll) + NUM_W'(r_d_mm) - NUM_W'(r_d_rr));
        r_e_ng  <= $signed(NUM_W'(r_d_rr) + NUM_W'(r_d_ll) - NUM_W'(r_d_mm));
        r_e_db  <= DEN_W'({r_d_lm, 1'b0});
        r_e_dg  <= DEN_W'({r_d_lr, 1'b0});
        r_f_anb <= REM_W'(r_e_nb[NUM_W-1] ? -r_e_nb : r_e_nb);
        r_f_ang <= REM_W'(r_e_ng[NUM_W-1] ? -r_e_ng : r_e_ng);
        r_f_db  <= r_e_db;
        r_f_dg  <= r_e_dg;
        r_g_anb <= r_f_anb;
        r_g_ang <= r_f_ang;
        r_g_db  <= r_f_db;
        r_g_dg  <= r_f_dg;
    end

    // ---------------- cosine dividers ----------------
    logic [REM_W-1:0] w_db_rem [0:DIV_STEPS];
    logic [DEN_W-1:0] w_db_den [0:DIV_STEPS];
    logic [QUO_W-1:0] w_db_quo [0:DIV_STEPS];
    logic [REM_W-1:0] w_dg_rem [0:DIV_STEPS];
    logic [DEN_W-1:0] w_dg_den [0:DIV_STEPS];
    logic [QUO_W-1:0] w_dg_quo [0:DIV_STEPS];
    t_side            r_sd2    [0:DIV_STEPS-1];

    assign w_db_rem[0] = r_g_anb;
    assign w_db_den[0] = r_g_db;
    assign w_db_quo[0] = '0;
    assign w_dg_rem[0] = r_g_ang;
    assign w_dg_den[0] = r_g_dg;
    assign w_dg_quo[0] = '0;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        fbik_div_cell u_beta (
            .i_clk (i_clk),
            .i_rem (w_db_rem[k]),
            .i_den (w_db_den[k]),
            .i_quo (w_db_quo[k]),
            .o_rem (w_db_rem[k+1]),
            .o_den (w_db_den[k+1]),
            .o_quo (w_db_quo[k+1])
        );
        fbik_div_cell u_gamma (
            .i_clk (i_clk),
            .i_rem (w_dg_rem[k]),
            .i_den (w_dg_den[k]),
            .i_quo (w_dg_quo[k]),
            .o_rem (w_dg_rem[k+1]),
            .o_den (w_dg_den[k+1]),
            .o_quo (w_dg_quo[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STEPS; k++) r_sd2[k] <= '0;
        end else begin
            r_sd2[0] <= r_g_sd;
            for (int k = 1; k < DIV_STEPS; k++) r_sd2[k] <= r_sd2[k-1];
        end
    end

    // ---------------- stages H, I: 1 - c^2 ----------------
    t_side               r_h_sd, r_i_sd;
    t_side               n_h_sd;
    logic [SQ_RAD_W-1:0] r_h_ab, r_h_ag, r_i_rb, r_i_rg;
    logic [QUO_W-1:0]    qb, qg;

    assign qb = w_db_quo[DIV_STEPS];
    assign qg = w_dg_quo[DIV_STEPS];

    always_comb begin
        n_h_sd       = r_sd2[DIV_STEPS-1];
        n_h_sd.qb    = qb;
        n_h_sd.qg    = qg;
        // a zero quotient is never negative
        n_h_sd.neg_b = r_sd2[DIV_STEPS-1].sg_b && (qb != '0);
        n_h_sd.neg_g = r_sd2[DIV_STEPS-1].sg_g && (qg != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_sd <= '0;
            r_i_sd <= '0;
        end else begin
            r_h_sd <= n_h_sd;
            r_i_sd <= r_h_sd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_ab <= qb * qb;
        r_h_ag <= qg * qg;
        r_i_rb <= ONE_SQ_Q60 - r_h_ab;
        r_i_rg <= ONE_SQ_Q60 - r_h_ag;
    end

    // ---------------- acos square roots ----------------
    logic [SQ_RAD_W-1:0]  w_sb_rad  [0:SQ_STEPS];
    logic [SQ_REM_W-1:0]  w_sb_rem  [0:SQ_STEPS];
    logic [SQ_ROOT_W-1:0] w_sb_root [0:SQ_STEPS];
    logic [SQ_RAD_W-1:0]  w_sg_rad  [0:SQ_STEPS];
    logic [SQ_REM_W-1:0]  w_sg_rem  [0:SQ_STEPS];
    logic [SQ_ROOT_W-1:0] w_sg_root [0:SQ_STEPS];
    t_side                r_sd3     [0:SQ_STEPS-1];

    assign w_sb_rad[0]  = r_i_rb;
    assign w_sb_rem[0]  = '0;
    assign w_sb_root[0] = '0;
    assign w_sg_rad[0]  = r_i_rg;
    assign w_sg_rem[0]  = '0;
    assign w_sg_root[0] = '0;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_acs
        fbik_sqrt_cell u_beta (
            .i_clk  (i_clk),
            .i_rad  (w_sb_rad[k]),
            .i_rem  (w_sb_rem[k]),
            .i_root (w_sb_root[k]),
            .o_rad  (w_sb_rad[k+1]),
            .o_rem  (w_sb_rem[k+1]),
            .o_root (w_sb_root[k+1])
        );
        fbik_sqrt_cell u_gamma (
            .i_clk  (i_clk),
            .i_rad  (w_sg_rad[k]),
            .i_rem  (w_sg_rem[k]),
            .i_root (w_sg_root[k]),
            .o_rad  (w_sg_rad[k+1]),
            .o_rem  (w_sg_rem[k+1]),
            .o_root (w_sg_root[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQ_STEPS; k++) r_sd3[k] <= '0;
        end else begin
            r_sd3[0] <= r_i_sd;
            for (int k = 1; k < SQ_STEPS; k++) r_sd3[k] <= r_sd3[k-1];
        end
    end

    // ---------------- stage J: CORDIC operands ----------------
    t_side                  r_j_sd;
    t_side                  sd3_out;
    logic signed [XD_W:0]   tx, ty;
    logic signed [CD_W-1:0] r_j_bx, r_j_by, r_j_gx, r_j_gy, r_j_tx, r_j_ty;

    // fold the target into the right half-plane
    always_comb begin
        sd3_out = r_sd3[SQ_STEPS-1];
        if (sd3_out.xd[XD_W-1]) begin
            tx = -(XD_W+1)'(sd3_out.xd);
            ty = -(XD_W+1)'(sd3_out.zd);
        end else begin
            tx = (XD_W+1)'(sd3_out.xd);
            ty = (XD_W+1)'(sd3_out.zd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_sd <= '0;
        end else begin
            r_j_sd <= sd3_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j_bx <= $signed(CD_W'(sd3_out.qb));
        r_j_by <= $signed(CD_W'(w_sb_root[SQ_STEPS]));
        r_j_gx <= $signed(CD_W'(sd3_out.qg));
        r_j_gy <= $signed(CD_W'(w_sg_root[SQ_STEPS]));
        r_j_tx <= $signed({{(CD_W-XD_W-21){tx[XD_W]}}, tx, 20'b0});
        r_j_ty <= $signed({{(CD_W-XD_W-21){ty[XD_W]}}, ty, 20'b0});
    end

    // ---------------- CORDIC chains ----------------
    logic signed [CD_W-1:0] w_cb_x [0:CORDIC_STEPS];
    logic signed [CD_W-1:0] w_cb_y [0:CORDIC_STEPS];
    logic signed [CZ_W-1:0] w_cb_z [0:CORDIC_STEPS];
    logic signed [CD_W-1:0] w_cg_x [0:CORDIC_STEPS];
    logic signed [CD_W-1:0] w_cg_y [0:CORDIC_STEPS];
    logic signed [CZ_W-1:0] w_cg_z [0:CORDIC_STEPS];
    logic signed [CD_W-1:0] w_ct_x [0:CORDIC_STEPS];
    logic signed [CD_W-1:0] w_ct_y [0:CORDIC_STEPS];
    logic signed [CZ_W-1:0] w_ct_z [0:CORDIC_STEPS];
    t_side                  r_sd4  [0:CORDIC_STEPS-1];

    assign w_cb_x[0] = r_j_bx;
    assign w_cb_y[0] = r_j_by;
    assign w_cb_z[0] = '0;
    assign w_cg_x[0] = r_j_gx;
    assign w_cg_y[0] = r_j_gy;
    assign w_cg_z[0] = '0;
    assign w_ct_x[0] = r_j_tx;
    assign w_ct_y[0] = r_j_ty;
    assign w_ct_z[0] = '0;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cor
        fbik_cordic_cell u_beta (
            .i_clk  (i_clk),
            .i_step (STEP_W'(k)),
            .i_x    (w_cb_x[k]),
            .i_y    (w_cb_y[k]),
            .i_z    (w_cb_z[k]),
            .o_x    (w_cb_x[k+1]),
            .o_y    (w_cb_y[k+1]),
            .o_z    (w_cb_z[k+1])
        );
        fbik_cordic_cell u_gamma (
            .i_clk  (i_clk),
            .i_step (STEP_W'(k)),
            .i_x    (w_cg_x[k]),
            .i_y    (w_cg_y[k]),
            .i_z    (w_cg_z[k]),
            .o_x    (w_cg_x[k+1]),
            .o_y    (w_cg_y[k+1]),
            .o_z    (w_cg_z[k+1])
        );
        fbik_cordic_cell u_theta (
            .i_clk  (i_clk),
            .i_step (STEP_W'(k)),
            .i_x    (w_ct_x[k]),
            .i_y    (w_ct_y[k]),
            .i_z    (w_ct_z[k]),
            .o_x    (w_ct_x[k+1]),
            .o_y    (w_ct_y[k+1]),
            .o_z    (w_ct_z[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CORDIC_STEPS; k++) r_sd4[k] <= '0;
        end else begin
            r_sd4[0] <= r_j_sd;
            for (int k = 1; k < CORDIC_STEPS; k++) r_sd4[k] <= r_sd4[k-1];
        end
    end

    // ---------------- stages K..O: angles, rounding, limits ----------------
    t_side                   sd4_out;
    t_side                   r_k_sd, r_l_sd, r_m_sd, r_n_sd;
    logic signed [ANG_W-1:0] zb, zg, zt;
    logic signed [ANG_W-1:0] r_k_beta, r_k_gamma, r_k_te;
    logic signed [ANG_W-1:0] r_l_t2, r_l_pb, r_m_t2, r_m_pb, r_m_a1;
    logic signed [Q16_W-1:0] r_n_a1, r_n_a2, r_n_ap;
    logic                    lim_fail;

    logic                       r_o_vld;
    logic signed [ANGLE_W-1:0]  r_o_a1, r_o_a2, r_o_ap;
    logic [STATUS_W-1:0]        r_o_status;

    always_comb begin
        sd4_out  = r_sd4[CORDIC_STEPS-1];
        zb       = ANG_W'(w_cb_z[CORDIC_STEPS]);
        zg       = ANG_W'(w_cg_z[CORDIC_STEPS]);
        zt       = ANG_W'(w_ct_z[CORDIC_STEPS]);
        lim_fail = outside(r_n_a1, r_act1_min, r_act1_max)
                || outside(r_n_a2, r_act2_min, r_act2_max)
                || outside(r_n_ap, r_passive_min, r_passive_max);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_sd  <= '0;
            r_l_sd  <= '0;
            r_m_sd  <= '0;
            r_n_sd  <= '0;
            r_o_vld <= 1'b0;
        end else begin
            r_k_sd  <= sd4_out;
            r_l_sd  <= r_k_sd;
            r_m_sd  <= r_l_sd;
            r_n_sd  <= r_m_sd;
            r_o_vld <= r_n_sd.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k_beta  <= sd4_out.neg_b ? (PI_Q30 - zb) : zb;
        r_k_gamma <= sd4_out.neg_g ? (PI_Q30 - zg) : zg;
        // vertical target: straight up or down
        if (sd4_out.xd == '0) begin
            r_k_te <= (sd4_out.zd > 0) ? PIH_Q30 : -PIH_Q30;
        end else begin
            r_k_te <= zt;
        end
        r_l_t2 <= r_k_gamma + r_k_te;
        r_l_pb <= PI_Q30 - r_k_beta;
        r_m_t2 <= r_l_t2;
        r_m_pb <= r_l_pb;
        r_m_a1 <= r_l_pb - r_l_t2;
        r_n_a1 <= to_q16(r_m_a1);
        r_n_a2 <= to_q16(r_m_t2);
        r_n_ap <= to_q16(r_m_pb);
        if (r_n_sd.ok) begin
            r_o_a1     <= r_n_a1[ANGLE_W-1:0];
            r_o_a2     <= r_n_a2[ANGLE_W-1:0];
            r_o_ap     <= r_n_ap[ANGLE_W-1:0];
            r_o_status <= lim_fail ? ST_LIMIT : ST_OK;
        end else begin
            r_o_a1     <= '0;
            r_o_a2     <= '0;
            r_o_ap     <= '0;
            r_o_status <= ST_REACH;
        end
    end

    assign o_valid         = r_o_vld;
    assign o_angle_act1    = r_o_a1;
    assign o_angle_act2    = r_o_a2;
    assign o_angle_passive = r_o_ap;
    assign o_status        = r_o_status;

endmodule
`default_nettype wire
